// ===== rtl/rbs_pkg.sv =====
// Shared types and constants for the ray/box slab test block.
// No dependencies; imported by the divider and the top level.
package rbs_pkg;

  localparam int CoordW = 32;
  localparam int FracW  = 16;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  localparam logic OpLoad = 1'b0;
  localparam logic OpTest = 1'b1;

  // Input word: box corners on a load, ray on a test.
  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] vec_a_x;
    logic signed [CoordW-1:0] vec_a_y;
    logic signed [CoordW-1:0] vec_a_z;
    logic signed [CoordW-1:0] vec_b_x;
    logic signed [CoordW-1:0] vec_b_y;
    logic signed [CoordW-1:0] vec_b_z;
    logic [CoordW-2:0]        seg_limit;
  } rbs_in_t;

  // Result word of one ray test.
  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] distance;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
    logic signed [CoordW-1:0] hit_z;
  } rbs_out_t;

endpackage

// ===== rtl/ray_box_slab_intersection_core.sv =====
// Top level of the ray/box slab test: sequencer, box store, shared divider
// and multiplier. Depends on rbs_pkg and rbs_div.
//
// Usage. Input words arrive on in_valid/in_stall/in_data and are taken at an
// edge with in_valid high and in_stall low. A load word (op 0) stores the box
// corners at that edge and gives no result; the next word may follow at once.
// A test word (op 1) gives exactly one result word on out_valid/out_stall/
// out_data. Configuration: cfg_we writes cfg_data into the edge rejection bit.
// A test steps through the axes in turn: an axis with zero direction is
// checked against its slab directly; one with nonzero direction waits on the
// single bit-serial divider for two slab quotients, low plane then high, so
// up to six in all. Then follow the decision, the hit point on a hit (a
// multiply and an add per axis), and the output register.
// in_stall stays high while a test is in progress; one test at a time, so the
// next word is taken once the previous test has reached the output register.
// A finished result sits in the output register; a new word is accepted while
// it waits, but the next result holds until the receiver takes the first.
// Reset clears the box to all zero, the edge bit, and empties the output.
module ray_box_slab_intersection_core
  import rbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  rbs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rbs_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_AXIS   = 8'b0000_0010,
    ST_WAIT1  = 8'b0000_0100,
    ST_WAIT2  = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_MUL    = 8'b0010_0000,
    ST_ADD    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } rbs_state_t;

  localparam int SumW = CoordW + 1 + FracW;

  rbs_state_t state;
  logic [1:0] axis;
  logic       edge_start_rejects;

  logic signed [CoordW-1:0] box_lo [3];
  logic signed [CoordW-1:0] box_hi [3];
  logic signed [CoordW-1:0] org    [3];
  logic signed [CoordW-1:0] dir    [3];
  logic signed [CoordW-1:0] hit_pt [3];
  logic [CoordW-2:0]        len;
  logic signed [CoordW-1:0] tmin;
  logic signed [CoordW-1:0] tmax;
  logic signed [CoordW-1:0] t1;
  logic                     miss;
  logic                     hit;
  logic signed [2*CoordW-1:0] prod;

  logic                     div_start;
  logic signed [CoordW:0]   div_num;
  logic                     div_done;
  logic signed [CoordW-1:0] div_q;

  logic signed [CoordW-1:0] lo_sel, hi_sel, org_sel, dir_sel;
  logic signed [CoordW-1:0] near, far;
  logic signed [SumW-1:0]   sum;
  logic signed [CoordW-1:0] sum_sat;
  logic                     miss_now;
  logic                     out_free;

  assign lo_sel  = box_lo[axis];
  assign hi_sel  = box_hi[axis];
  assign org_sel = org[axis];
  assign dir_sel = dir[axis];

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Divider operands: low slab plane first, then high.
  assign div_start = ((state == ST_AXIS) && (dir_sel != '0)) ||
                     ((state == ST_WAIT1) && div_done);
  assign div_num   = (state == ST_AXIS) ?
                     ({lo_sel[CoordW-1], lo_sel} - {org_sel[CoordW-1], org_sel}) :
                     ({hi_sel[CoordW-1], hi_sel} - {org_sel[CoordW-1], org_sel});

  rbs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dir_sel),
    .done  (div_done),
    .quot  (div_q)
  );

  // Ordering of the two slab parameters of this axis.
  assign near = (t1 < div_q) ? t1 : div_q;
  assign far  = (t1 < div_q) ? div_q : t1;

  // Final miss decision over the accumulated interval.
  assign miss_now = miss ||
                    ((tmax == '0) && edge_start_rejects) ||
                    (tmax < 0) ||
                    (tmin > tmax) ||
                    (tmin > $signed({1'b0, len}));

  // Hit coordinate: origin plus floored product, saturated.
  assign sum = {{(SumW-CoordW){org_sel[CoordW-1]}}, org_sel} +
               {prod[2*CoordW-1], prod[2*CoordW-1:FracW]};
  always_comb begin
    if (sum[SumW-1:CoordW-1] == '0 || sum[SumW-1:CoordW-1] == '1)
      sum_sat = sum[CoordW-1:0];
    else if (sum[SumW-1])
      sum_sat = CoordMin;
    else
      sum_sat = CoordMax;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_start_rejects <= 1'b0;
    end else if (cfg_we) begin
      edge_start_rejects <= cfg_data;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_lo[i] <= '0;
        box_hi[i] <= '0;
      end
    end else begin
      // The output step sets the valid itself when it hands over a word.
      if (out_valid && !out_stall && state != ST_DONE)
        out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.op == OpLoad) begin
              box_lo[0] <= in_data.vec_a_x;
              box_lo[1] <= in_data.vec_a_y;
              box_lo[2] <= in_data.vec_a_z;
              box_hi[0] <= in_data.vec_b_x;
              box_hi[1] <= in_data.vec_b_y;
              box_hi[2] <= in_data.vec_b_z;
            end else begin
              org[0] <= in_data.vec_a_x;
              org[1] <= in_data.vec_a_y;
              org[2] <= in_data.vec_a_z;
              dir[0] <= in_data.vec_b_x;
              dir[1] <= in_data.vec_b_y;
              dir[2] <= in_data.vec_b_z;
              len    <= in_data.seg_limit;
              tmin   <= CoordMin;
              tmax   <= CoordMax;
              miss   <= 1'b0;
              axis   <= '0;
              state  <= ST_AXIS;
            end
          end
        end
        ST_AXIS: begin
          if (dir_sel != '0) begin
            state <= ST_WAIT1;
          end else begin
            if (org_sel < lo_sel || org_sel > hi_sel)
              miss <= 1'b1;
            if (axis == 2'd2) begin
              state <= ST_DECIDE;
            end else begin
              axis <= axis + 1'b1;
            end
          end
        end
        ST_WAIT1: begin
          if (div_done) begin
            t1    <= div_q;
            state <= ST_WAIT2;
          end
        end
        ST_WAIT2: begin
          if (div_done) begin
            if (near > tmin) tmin <= near;
            if (far < tmax) tmax <= far;
            if (axis == 2'd2) begin
              state <= ST_DECIDE;
            end else begin
              axis  <= axis + 1'b1;
              state <= ST_AXIS;
            end
          end
        end
        ST_DECIDE: begin
          hit  <= !miss_now;
          axis <= '0;
          state <= miss_now ? ST_DONE : ST_MUL;
        end
        ST_MUL: begin
          prod  <= dir_sel * tmin;
          state <= ST_ADD;
        end
        ST_ADD: begin
          hit_pt[axis] <= sum_sat;
          if (axis == 2'd2) begin
            state <= ST_DONE;
          end else begin
            axis  <= axis + 1'b1;
            state <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_data.hit      <= hit;
            out_data.distance <= hit ? tmin : CoordMax;
            out_data.hit_x    <= hit ? hit_pt[0] : '0;
            out_data.hit_y    <= hit ? hit_pt[1] : '0;
            out_data.hit_z    <= hit ? hit_pt[2] : '0;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_miss_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |->
      (out_data.distance == CoordMax && out_data.hit_x == '0 &&
       out_data.hit_y == '0 && out_data.hit_z == '0))
    else $error("miss word carries a distance or a point");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared outside the output step");

  a_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT1 || state == ST_WAIT2))
    else $error("quotient finished while the sequencer was not waiting");

endmodule

// ===== rtl/rbs_div.sv =====
// Bit-serial signed divider: (num << 16) / den, truncated and saturated.
// Depends on rbs_pkg for the coordinate width and limits.
module rbs_div
  import rbs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [CoordW:0]   num,
  input  logic signed [CoordW-1:0] den,
  output logic                     done,
  output logic signed [CoordW-1:0] quot
);

  localparam int DvdW = CoordW + 1 + FracW;
  localparam int CntW = $clog2(DvdW + 1);

  logic              busy;
  logic [CntW-1:0]   cnt;
  logic [DvdW-1:0]   dvd;
  logic [DvdW-1:0]   q;
  logic [CoordW-1:0] rem;
  logic [CoordW-1:0] md;
  logic              neg;

  logic [CoordW:0]   mn;
  logic [CoordW:0]   trial;
  logic              take;

  // Magnitude of the numerator and one restoring step.
  assign mn    = num[CoordW] ? (~num + 1'b1) : num;
  assign trial = {rem, dvd[DvdW-1]};
  assign take  = trial >= {1'b0, md};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DvdW);
        dvd  <= {mn, {FracW{1'b0}}};
        q    <= '0;
        rem  <= '0;
        md   <= den[CoordW-1] ? (~den + 1'b1) : den;
        neg  <= num[CoordW] ^ den[CoordW-1];
      end else if (busy) begin
        rem <= take ? CoordW'(trial - {1'b0, md}) : trial[CoordW-1:0];
        q   <= {q[DvdW-2:0], take};
        dvd <= {dvd[DvdW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    if (neg) begin
      if ((|q[DvdW-1:CoordW]) || (q[CoordW-1] && (|q[CoordW-2:0])))
        quot = CoordMin;
      else
        quot = ~q[CoordW-1:0] + 1'b1;
    end else begin
      if (|q[DvdW-1:CoordW-1])
        quot = CoordMax;
      else
        quot = q[CoordW-1:0];
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("divider busy and done together");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done longer than one cycle");

endmodule
